### src/assert_macros.svh
// Assertion macros used by the port-level checker sadc_chk.
// Plain text only; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

### src/sadc_pkg.sv
// Shared types, constants and command codes of the serial ADC read controller.
// No dependencies.
package sadc_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int MAX_POWER_DEF   = 15;

	localparam int FUNC_W      = 3;
	localparam int POWER_W     = 8;
	localparam int SAMPLE_W    = 16;
	localparam int TICK_W      = 32;
	localparam int PULSE_W     = 12;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 24;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic [FUNC_W-1:0] CMD_NONE       = 3'd0;
	localparam logic [FUNC_W-1:0] CMD_READ       = 3'd1;
	localparam logic [FUNC_W-1:0] CMD_READ_NOACQ = 3'd2;
	localparam logic [FUNC_W-1:0] CMD_AVG        = 3'd3;
	localparam logic [FUNC_W-1:0] CMD_CAL        = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_ACQUIRE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONVERT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_CLOCK  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_PULSES  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_TIMEOUT = 3'd5;

	localparam logic [15:0] RST_ACQUIRE     = 16'd30;
	localparam logic [15:0] RST_CONVERT     = 16'd70;
	localparam logic [7:0]  RST_SETTLE      = 8'd1;
	localparam logic [7:0]  RST_HALF_CLOCK  = 8'd1;
	localparam logic [11:0] RST_CAL_PULSES  = 12'd1024;
	localparam logic [31:0] RST_CAL_TIMEOUT = 32'd200000000;

	typedef struct packed {
		logic [15:0]        acquire;
		logic [15:0]        convert;
		logic [7:0]         settle;
		logic [7:0]         half_clock;
		logic [PULSE_W-1:0] cal_pulses;
		logic [31:0]        cal_timeout;
	} cfg_t;

	typedef struct packed {
		logic                cnvst;
		logic                sck;
		logic                busy;
		logic                sample_valid;
		logic [SAMPLE_W-1:0] sample;
		logic                cal_done;
		logic                cal_ok;
	} result_t;

endpackage

### src/sadc_cfg.sv
// Configuration register file of the serial ADC read controller.
// Depends on sadc_pkg.
module sadc_cfg
	import sadc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.acquire     <= RST_ACQUIRE;
			cfg_q.convert     <= RST_CONVERT;
			cfg_q.settle      <= RST_SETTLE;
			cfg_q.half_clock  <= RST_HALF_CLOCK;
			cfg_q.cal_pulses  <= RST_CAL_PULSES;
			cfg_q.cal_timeout <= RST_CAL_TIMEOUT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACQUIRE:     cfg_q.acquire     <= cfg_data[15:0];
				REG_CONVERT:     cfg_q.convert     <= cfg_data[15:0];
				REG_SETTLE:      cfg_q.settle      <= cfg_data[7:0];
				REG_HALF_CLOCK:  cfg_q.half_clock  <= cfg_data[7:0];
				REG_CAL_PULSES:  cfg_q.cal_pulses  <= cfg_data[PULSE_W-1:0];
				REG_CAL_TIMEOUT: cfg_q.cal_timeout <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### src/sadc_seq.sv
// Pin sequencer: command start, phase timing, bit capture, averaging, calibration.
// Depends on sadc_pkg; state advances once per processed tick.
module sadc_seq
	import sadc_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int MAX_POWER   = MAX_POWER_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  cfg_t               cfg,
	input  logic [FUNC_W-1:0]  func,
	input  logic [POWER_W-1:0] power,
	input  logic               sdo,
	output result_t            res
);

	localparam int ACC_W   = SAMPLE_BITS + MAX_POWER;
	localparam int SHAMT_W = (MAX_POWER > 0) ? $clog2(MAX_POWER + 1) : 1;
	localparam int READS_W = MAX_POWER + 1;
	localparam logic [PULSE_W-1:0] SAMPLE_LIMIT = PULSE_W'(SAMPLE_BITS);

	typedef enum logic [2:0] {
		PH_IDLE, PH_ACQ, PH_CONV, PH_SETTLE, PH_HI, PH_LO, PH_WAIT
	} phase_t;

	phase_t                   phase_q, ph_d;
	logic [FUNC_W-1:0]        mode_q, mode_d;
	logic [TICK_W-1:0]        tick_q, tick_d;
	logic [PULSE_W-1:0]       pulse_q, pulse_d;
	logic [SAMPLE_BITS-1:0]   shift_q, shift_d;
	logic [ACC_W-1:0]         acc_q, acc_d;
	logic [READS_W-1:0]       reads_q, reads_d;
	logic [SHAMT_W-1:0]       shamt_q, shamt_d;
	logic                     cnvst_q, cnvst_d;
	logic                     sck_q, sck_d;

	logic [SHAMT_W-1:0]       pw_clamped;
	logic [TICK_W-1:0]        half;
	logic [PULSE_W-1:0]       limit;
	logic [TICK_W:0]          wait_inc;
	logic                     busy, ev_valid, ev_done, ev_ok;
	logic [SAMPLE_W-1:0]      ev_sample;

	assign pw_clamped = (power > POWER_W'(MAX_POWER)) ? SHAMT_W'(MAX_POWER)
	                                                  : SHAMT_W'(power);
	assign half = (cfg.half_clock == '0) ? TICK_W'(1) : TICK_W'(cfg.half_clock);

	always_comb begin
		ph_d      = phase_q;
		mode_d    = mode_q;
		tick_d    = tick_q;
		pulse_d   = pulse_q;
		shift_d   = shift_q;
		acc_d     = acc_q;
		reads_d   = reads_q;
		shamt_d   = shamt_q;
		cnvst_d   = cnvst_q;
		sck_d     = sck_q;
		busy      = 1'b0;
		ev_valid  = 1'b0;
		ev_sample = '0;
		ev_done   = 1'b0;
		ev_ok     = 1'b0;
		wait_inc  = '0;
		limit     = SAMPLE_LIMIT;

		// command start, idle only
		if (phase_q == PH_IDLE && func >= CMD_READ && func <= CMD_CAL) begin
			mode_d = func;
			acc_d  = '0;
			if (func == CMD_AVG) begin
				shamt_d = pw_clamped;
				reads_d = READS_W'(1) << pw_clamped;
			end else begin
				shamt_d = '0;
				reads_d = '0;
			end
			if (func == CMD_READ_NOACQ || func == CMD_AVG) begin
				ph_d   = PH_CONV;
				tick_d = TICK_W'(cfg.convert);
			end else begin
				ph_d   = PH_ACQ;
				tick_d = TICK_W'(cfg.acquire);
			end
		end

		// skip empty phases
		if (ph_d == PH_ACQ && tick_d == '0) begin
			ph_d   = PH_CONV;
			tick_d = TICK_W'(cfg.convert);
		end
		if (ph_d == PH_CONV && tick_d == '0) begin
			ph_d   = PH_SETTLE;
			tick_d = TICK_W'(cfg.settle);
		end
		if (ph_d == PH_SETTLE && tick_d == '0) begin
			pulse_d = '0;
			shift_d = '0;
			if (mode_d == CMD_CAL && cfg.cal_pulses == '0) begin
				ph_d   = PH_WAIT;
				tick_d = '0;
			end else begin
				ph_d   = PH_HI;
				tick_d = half;
			end
		end

		case (ph_d)
			PH_WAIT: begin
				busy     = 1'b1;
				sck_d    = 1'b0;
				wait_inc = {1'b0, tick_d} + (TICK_W + 1)'(1);
				if (sdo) begin
					ev_done = 1'b1;
					ev_ok   = 1'b1;
				end else if (wait_inc >= {1'b0, cfg.cal_timeout}) begin
					ev_done = 1'b1;
				end else begin
					tick_d = wait_inc[TICK_W-1:0];
				end
				if (ev_done) begin
					cnvst_d = 1'b1;
					ph_d    = PH_IDLE;
				end
			end
			PH_ACQ, PH_CONV, PH_SETTLE, PH_HI, PH_LO: begin
				busy = 1'b1;
				case (ph_d)
					PH_ACQ:    cnvst_d = 1'b0;
					PH_CONV:   cnvst_d = 1'b1;
					PH_SETTLE: begin
						cnvst_d = 1'b0;
						sck_d   = 1'b0;
					end
					PH_HI:     sck_d = 1'b1;
					default:   sck_d = 1'b0;
				endcase
				// bit taken on the last tick of sck high
				if (ph_d == PH_HI && tick_d == TICK_W'(1))
					shift_d = {shift_d[SAMPLE_BITS-2:0], sdo};
				tick_d = tick_d - TICK_W'(1);
				if (tick_d == '0) begin
					case (ph_d)
						PH_ACQ: begin
							ph_d   = PH_CONV;
							tick_d = TICK_W'(cfg.convert);
						end
						PH_CONV: begin
							ph_d   = PH_SETTLE;
							tick_d = TICK_W'(cfg.settle);
						end
						PH_SETTLE: begin
							pulse_d = '0;
							shift_d = '0;
							if (mode_d == CMD_CAL && cfg.cal_pulses == '0) begin
								ph_d   = PH_WAIT;
								tick_d = '0;
							end else begin
								ph_d   = PH_HI;
								tick_d = half;
							end
						end
						PH_HI: begin
							ph_d   = PH_LO;
							tick_d = half;
						end
						default: begin
							limit   = (mode_d == CMD_CAL) ? cfg.cal_pulses : SAMPLE_LIMIT;
							pulse_d = pulse_d + PULSE_W'(1);
							if (pulse_d < limit) begin
								ph_d   = PH_HI;
								tick_d = half;
							end else if (mode_d == CMD_CAL) begin
								ph_d   = PH_WAIT;
								tick_d = '0;
							end else if (mode_d == CMD_AVG) begin
								acc_d = acc_d + ACC_W'(shift_d);
								if (reads_d != '0)
									reads_d = reads_d - READS_W'(1);
								if (reads_d != '0) begin
									ph_d   = PH_CONV;
									tick_d = TICK_W'(cfg.convert);
								end else begin
									ev_valid  = 1'b1;
									ev_sample = SAMPLE_W'(acc_d >> shamt_d);
									ph_d      = PH_IDLE;
								end
							end else begin
								ev_valid  = 1'b1;
								ev_sample = SAMPLE_W'(shift_d);
								ph_d      = PH_IDLE;
							end
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			mode_q  <= CMD_NONE;
			tick_q  <= '0;
			pulse_q <= '0;
			shift_q <= '0;
			acc_q   <= '0;
			reads_q <= '0;
			shamt_q <= '0;
			cnvst_q <= 1'b0;
			sck_q   <= 1'b0;
		end else if (step) begin
			phase_q <= ph_d;
			mode_q  <= mode_d;
			tick_q  <= tick_d;
			pulse_q <= pulse_d;
			shift_q <= shift_d;
			acc_q   <= acc_d;
			reads_q <= reads_d;
			shamt_q <= shamt_d;
			cnvst_q <= cnvst_d;
			sck_q   <= sck_d;
		end
	end

	assign res.cnvst        = cnvst_d;
	assign res.sck          = sck_d;
	assign res.busy         = busy;
	assign res.sample_valid = ev_valid;
	assign res.sample       = ev_sample;
	assign res.cal_done     = ev_done;
	assign res.cal_ok       = ev_ok;

endmodule

### src/serial_adc_read_controller.sv
// Channel  | dir | tdata fields (lsb first)                                | width
// s_*      | in  | func[2:0] power[10:3] sdo[11], zero pad                  | 16
// m_*      | out | cnvst sck busy_res sample_valid sample[19:4] cal_done    | 24
//          |     | cal_ok, zero pad                                         |
// cfg_*    | in  | cfg_index selects register, cfg_data written on cfg_we   | 3/32
// One request per clock while the output is not stalled: input register, sequencer logic, result register.
// An accepted request is held in the input register and its result in the result register.
// Output stall backs up through the input register to s_tready.
// Async reset clears pipeline valids and sequencer state and loads config defaults.
module serial_adc_read_controller
	import sadc_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int MAX_POWER   = MAX_POWER_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // func[2:0], power[10:3], sdo[11]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // cnvst, sck, busy_res, sample_valid,
	                                          // sample[19:4], cal_done, cal_ok
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t               cfg;
	result_t            res;
	result_t            res_s2;
	logic               valid_s1, valid_s2;
	logic [FUNC_W-1:0]  func_s1;
	logic [POWER_W-1:0] power_s1;
	logic               sdo_s1;
	logic               adv, step;

	assign adv      = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign step     = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (adv)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1  <= s_tdata[2:0];
			power_s1 <= s_tdata[10:3];
			sdo_s1   <= s_tdata[11];
		end
		if (step)
			res_s2 <= res;
	end

	sadc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sadc_seq #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_POWER   (MAX_POWER)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cfg    (cfg),
		.func   (func_s1),
		.power  (power_s1),
		.sdo    (sdo_s1),
		.res    (res)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, res_s2.cal_ok, res_s2.cal_done, res_s2.sample,
	                   res_s2.sample_valid, res_s2.busy, res_s2.sck, res_s2.cnvst};

endmodule

### src/sadc_chk.sv
// Port-level checker for the serial ADC read controller, bound to the top level.
// Depends on sadc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sadc_chk
	import sadc_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	logic cnvst, busy, sample_valid, cal_done, cal_ok;
	logic [SAMPLE_W-1:0] sample;

	assign cnvst        = m_tdata[0];
	assign busy         = m_tdata[2];
	assign sample_valid = m_tdata[3];
	assign sample       = m_tdata[19:4];
	assign cal_done     = m_tdata[20];
	assign cal_ok       = m_tdata[21];

	// input side only stalls behind a stalled, full output
	`ASSERT_IMPL(a_stall_cause, clk, arst_n, !s_tready, m_tvalid && !m_tready)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// completions happen inside a busy tick and never together
	`ASSERT_IMPL(a_event_busy, clk, arst_n, m_tvalid && (sample_valid || cal_done), busy && !(sample_valid && cal_done))
	// calibration pass implies done and cnvst left high
	`ASSERT_IMPL(a_cal_ok, clk, arst_n, m_tvalid && cal_ok, cal_done && cnvst)
	`ASSERT_IMPL(a_sample_zero, clk, arst_n, m_tvalid && !sample_valid, sample == '0)

endmodule

bind serial_adc_read_controller sadc_chk u_sadc_chk (.*);

### verif/sadc_checker.sv
// Checker for the serial ADC read controller: watches the request, result and
// register write ports, predicts every pin tick and compares it in order.
// Depends on sadc_pkg.
module sadc_checker
	import sadc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // func[2:0], power[10:3], sdo[11]
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,   // cnvst, sck, busy_res, sample_valid,
	                                          // sample[19:4], cal_done, cal_ok
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     error_count,
	output int                     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {
		PH_IDLE, PH_ACQ, PH_CONV, PH_SETTLE, PH_HI, PH_LO, PH_WAIT
	} seq_phase_e;

	cfg_t                regs;
	seq_phase_e          phase;
	logic [FUNC_W-1:0]   mode;
	logic [TICK_W-1:0]   ticks;
	logic [PULSE_W-1:0]  pulses;
	logic [SAMPLE_W-1:0] shreg;
	logic [31:0]         acc;
	logic [16:0]         reads_left;
	logic [3:0]          shamt;
	logic                cnvst_q, sck_q;
	logic                ev_valid, ev_done, ev_ok;
	logic [SAMPLE_W-1:0] ev_sample;

	result_t expected_pins[$];

	function automatic logic [TICK_W-1:0] half_len();
		return (regs.half_clock == 8'd0) ? 32'd1 : 32'(regs.half_clock);
	endfunction

	function automatic string show(result_t r);
		return $sformatf("cnvst=%b sck=%b busy=%b valid=%b sample=%h done=%b ok=%b",
			r.cnvst, r.sck, r.busy, r.sample_valid, r.sample, r.cal_done, r.cal_ok);
	endfunction

	task automatic advance_phase();
		logic [PULSE_W-1:0] limit;
		case (phase)
			PH_ACQ: begin
				phase = PH_CONV;
				ticks = 32'(regs.convert);
			end
			PH_CONV: begin
				phase = PH_SETTLE;
				ticks = 32'(regs.settle);
			end
			PH_SETTLE: begin
				pulses = '0;
				shreg = '0;
				if (mode == CMD_CAL && regs.cal_pulses == '0) begin
					phase = PH_WAIT;
					ticks = '0;
				end else begin
					phase = PH_HI;
					ticks = half_len();
				end
			end
			PH_HI: begin
				phase = PH_LO;
				ticks = half_len();
			end
			PH_LO: begin
				limit = (mode == CMD_CAL) ? regs.cal_pulses : PULSE_W'(SAMPLE_W);
				pulses++;
				if (pulses < limit) begin
					phase = PH_HI;
					ticks = half_len();
				end else if (mode == CMD_CAL) begin
					phase = PH_WAIT;
					ticks = '0;
				end else if (mode == CMD_AVG) begin
					acc += 32'(shreg);
					if (reads_left > 0)
						reads_left--;
					if (reads_left > 0) begin
						phase = PH_CONV;
						ticks = 32'(regs.convert);
					end else begin
						ev_valid = 1'b1;
						ev_sample = SAMPLE_W'(acc >> shamt);
						phase = PH_IDLE;
					end
				end else begin
					ev_valid = 1'b1;
					ev_sample = shreg;
					phase = PH_IDLE;
				end
			end
			default: phase = PH_IDLE;
		endcase
	endtask

	task automatic predict_pins(input logic [FUNC_W-1:0] func, input logic [POWER_W-1:0] power,
			input logic sdo, output result_t r);
		logic                busy;
		logic [POWER_W-1:0] pw;
		int                  guard;
		busy = 1'b0;
		ev_valid = 1'b0;
		ev_done = 1'b0;
		ev_ok = 1'b0;
		ev_sample = '0;

		if (phase == PH_IDLE && func >= CMD_READ && func <= CMD_CAL) begin
			mode = func;
			acc = '0;
			if (func == CMD_AVG) begin
				pw = (power > MAX_POWER_DEF) ? POWER_W'(MAX_POWER_DEF) : power;
				shamt = pw[3:0];
				reads_left = 17'd1 << pw;
			end else begin
				shamt = '0;
				reads_left = '0;
			end
			if (func == CMD_READ_NOACQ || func == CMD_AVG) begin
				phase = PH_CONV;
				ticks = 32'(regs.convert);
			end else begin
				phase = PH_ACQ;
				ticks = 32'(regs.acquire);
			end
		end

		for (guard = 0; guard < 8 && phase >= PH_ACQ && phase <= PH_LO && ticks == '0; guard++)
			advance_phase();

		if (phase == PH_WAIT) begin
			busy = 1'b1;
			sck_q = 1'b0;
			if (sdo) begin
				ev_done = 1'b1;
				ev_ok = 1'b1;
			end else if ({1'b0, ticks} + 33'd1 >= {1'b0, regs.cal_timeout}) begin
				ev_done = 1'b1;
			end else begin
				ticks++;
			end
			if (ev_done) begin
				cnvst_q = 1'b1;
				phase = PH_IDLE;
			end
		end else if (phase != PH_IDLE) begin
			busy = 1'b1;
			case (phase)
				PH_ACQ:    cnvst_q = 1'b0;
				PH_CONV:   cnvst_q = 1'b1;
				PH_SETTLE: begin
					cnvst_q = 1'b0;
					sck_q = 1'b0;
				end
				PH_HI:     sck_q = 1'b1;
				PH_LO:     sck_q = 1'b0;
				default:   ;
			endcase
			// bit captured on the last tick of each sck high level
			if (phase == PH_HI && ticks == 32'd1)
				shreg = {shreg[SAMPLE_W-2:0], sdo};
			ticks--;
			if (ticks == '0)
				advance_phase();
		end

		r.cnvst = cnvst_q;
		r.sck = sck_q;
		r.busy = busy;
		r.sample_valid = ev_valid;
		r.sample = ev_valid ? ev_sample : '0;
		r.cal_done = ev_done;
		r.cal_ok = ev_ok;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got, want;
		if (!arst_n) begin
			regs = '{RST_ACQUIRE, RST_CONVERT, RST_SETTLE, RST_HALF_CLOCK,
				RST_CAL_PULSES, RST_CAL_TIMEOUT};
			phase = PH_IDLE;
			mode = '0;
			ticks = '0;
			pulses = '0;
			shreg = '0;
			acc = '0;
			reads_left = '0;
			shamt = '0;
			cnvst_q = 1'b0;
			sck_q = 1'b0;
			expected_pins.delete();
			error_count = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ACQUIRE:     regs.acquire = cfg_data[15:0];
					REG_CONVERT:     regs.convert = cfg_data[15:0];
					REG_SETTLE:      regs.settle = cfg_data[7:0];
					REG_HALF_CLOCK:  regs.half_clock = cfg_data[7:0];
					REG_CAL_PULSES:  regs.cal_pulses = cfg_data[PULSE_W-1:0];
					REG_CAL_TIMEOUT: regs.cal_timeout = cfg_data;
					default:         ;
				endcase
			end

			if (m_tvalid && m_tready) begin
				got.cnvst = m_tdata[0];
				got.sck = m_tdata[1];
				got.busy = m_tdata[2];
				got.sample_valid = m_tdata[3];
				got.sample = m_tdata[SAMPLE_W+3:4];
				got.cal_done = m_tdata[SAMPLE_W+4];
				got.cal_ok = m_tdata[SAMPLE_W+5];
				if (expected_pins.size() == 0) begin
					error_count++;
					$display("%0t: mismatch, expected no result, got %s", $time, show(got));
				end else begin
					want = expected_pins.pop_front();
					if (got !== want) begin
						error_count++;
						$display("%0t: mismatch, expected %s, got %s",
							$time, show(want), show(got));
					end
				end
			end

			if (s_tvalid && s_tready) begin
				predict_pins(s_tdata[FUNC_W-1:0], s_tdata[FUNC_W+POWER_W-1:FUNC_W],
					s_tdata[FUNC_W+POWER_W], want);
				expected_pins.push_back(want);
			end
			pending = expected_pins.size();
		end
	end

endmodule

### verif/tb_top.sv
// Top of the serial ADC read controller bench: clock, reset, register setup and
// request stimulus under several idle and stall mixes; verdict from sadc_checker.
// Depends on sadc_pkg, serial_adc_read_controller and sadc_checker.
module tb_top
	import sadc_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [FUNC_W-1:0]    FUNC_UNUSED_A = 3'd5;
	localparam logic [FUNC_W-1:0]    FUNC_UNUSED_C = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI  = 3'd7;
	localparam int QUIET_LIMIT = 5000;
	localparam int RUN_CAP     = 2000000;
	localparam int IDLE_CAP    = 100000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	int   error_count, pending;
	int   idle_pct = 0;
	int   stall_pct = 0;
	int   n_sent = 0;
	int   n_back, n_done, quiet;
	logic last_busy;

	serial_adc_read_controller dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	sadc_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.error_count(error_count), .pending(pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(negedge clk) m_tready <= ($urandom_range(0, 99) >= stall_pct);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_back <= 0;
			n_done <= 0;
			last_busy <= 1'b0;
			quiet <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_back <= n_back + 1;
				last_busy <= m_tdata[2];
				if (m_tdata[3] || m_tdata[SAMPLE_W+4])
					n_done <= n_done + 1;
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
				quiet <= 0;
			end else if (quiet == QUIET_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	function automatic logic sdo_draw(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	task automatic send_tick(input logic [FUNC_W-1:0] func, input logic [POWER_W-1:0] power,
			input logic sdo);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, sdo, power, func};
		do @(posedge clk); while (!s_tready);
		n_sent++;
		@(negedge clk);
	endtask

	// stop requesting so the quiet-cycle watchdog ends the run
	task automatic freeze();
		s_tvalid <= 1'b0;
		forever @(negedge clk);
	endtask

	task automatic go_idle();
		int count;
		count = 0;
		s_tvalid <= 1'b0;
		do @(negedge clk); while (n_back != n_sent);
		while (last_busy) begin
			if (count == IDLE_CAP)
				freeze();
			send_tick(CMD_NONE, POWER_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			s_tvalid <= 1'b0;
			do @(negedge clk); while (n_back != n_sent);
			count++;
		end
	endtask

	// noisy: filler ticks carry random func codes, ignored while busy
	task automatic run_cmd(input logic [FUNC_W-1:0] func, input logic [POWER_W-1:0] power,
			input int pct, input bit noisy);
		int                 start, count;
		logic [FUNC_W-1:0]  f;
		logic [POWER_W-1:0] p;
		start = n_done;
		count = 0;
		send_tick(func, power, sdo_draw(pct));
		while (n_done == start) begin
			if (count == RUN_CAP)
				freeze();
			f = CMD_NONE;
			p = POWER_W'($urandom_range(0, 255));
			if (noisy) begin
				f = FUNC_W'($urandom_range(0, 7));
				if (f == CMD_AVG)
					p = 8'd1;
			end
			send_tick(f, p, sdo_draw(pct));
			count++;
		end
		go_idle();
	endtask

	// upper data bits carry junk to exercise masking to register width
	task automatic load_settings(input cfg_t c);
		go_idle();
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_ACQUIRE;
		cfg_data <= {16'($urandom()), c.acquire};
		@(negedge clk);
		cfg_index <= REG_CONVERT;
		cfg_data <= {16'($urandom()), c.convert};
		@(negedge clk);
		cfg_index <= REG_SETTLE;
		cfg_data <= {24'($urandom()), c.settle};
		@(negedge clk);
		cfg_index <= REG_HALF_CLOCK;
		cfg_data <= {24'($urandom()), c.half_clock};
		@(negedge clk);
		cfg_index <= REG_CAL_PULSES;
		cfg_data <= {20'($urandom()), c.cal_pulses};
		@(negedge clk);
		cfg_index <= REG_CAL_TIMEOUT;
		cfg_data <= c.cal_timeout;
		@(negedge clk);
		cfg_index <= REG_SPARE_LO;
		cfg_data <= $urandom();
		@(negedge clk);
		cfg_index <= REG_SPARE_HI;
		cfg_data <= $urandom();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		cfg_t               c;
		int                 ph, n, pct;
		logic [FUNC_W-1:0]  f;
		logic [POWER_W-1:0] p;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset register values
		run_cmd(CMD_READ, 8'd0, 50, 0);

		load_settings(cfg_t'{16'd3, 16'd2, 8'd1, 8'd1, 12'd3, 32'd5});
		run_cmd(CMD_READ, 8'hFF, 100, 0);
		run_cmd(CMD_READ_NOACQ, 8'd0, 0, 0);
		run_cmd(CMD_AVG, 8'd0, 50, 0);
		run_cmd(CMD_AVG, 8'd2, 50, 0);
		run_cmd(CMD_CAL, 8'd0, 0, 0);
		run_cmd(CMD_CAL, 8'd0, 10, 0);
		run_cmd(CMD_READ, 8'd0, 50, 1);
		for (f = FUNC_UNUSED_A; f != CMD_NONE; f++)
			send_tick(f, POWER_W'($urandom_range(0, 255)), 1'b1);
		send_tick(CMD_NONE, 8'hFF, 1'b0);
		go_idle();

		// every timed phase zero, half clock zero, no calibrate pulses, zero timeout
		load_settings(cfg_t'{16'd0, 16'd0, 8'd0, 8'd0, 12'd0, 32'd0});
		run_cmd(CMD_READ, 8'd0, 50, 0);
		run_cmd(CMD_AVG, 8'd1, 50, 0);
		run_cmd(CMD_CAL, 8'd0, 0, 0);
		run_cmd(CMD_CAL, 8'd0, 100, 0);

		for (ph = 0; ph < 8; ph++) begin
			c.acquire = 16'($urandom_range(0, 4));
			c.convert = 16'($urandom_range(0, 4));
			c.settle = 8'($urandom_range(0, 2));
			c.half_clock = 8'($urandom_range(0, 2));
			c.cal_pulses = 12'($urandom_range(0, 6));
			c.cal_timeout = 32'($urandom_range(0, 12));
			load_settings(c);
			case (ph % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 80;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 80;
				end
				default: begin
					idle_pct = 35;
					stall_pct = 35;
				end
			endcase
			pct = 50;
			for (n = 0; n < 30; n++) begin
				if (n % 10 == 0) begin
					case ($urandom_range(0, 4))
						0: pct = 0;
						1: pct = 10;
						2: pct = 50;
						3: pct = 90;
						default: pct = 100;
					endcase
				end
				f = ($urandom_range(0, 99) < 30) ?
					FUNC_W'($urandom_range(CMD_READ, FUNC_UNUSED_C)) : CMD_NONE;
				p = (f == CMD_AVG) ? POWER_W'($urandom_range(0, 3)) :
					POWER_W'($urandom_range(0, 255));
				send_tick(f, p, sdo_draw(pct));
			end
		end

		go_idle();
		repeat (8) @(negedge clk);
		if (error_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
